// ===== src/twdkm_pkg.sv =====
// Shared types, codes and constants for the two-wire display/key bus master.
`timescale 1ns / 1ps

package twdkm_pkg;

    // Field and port widths
    localparam int HALF_W      = 10;
    localparam int CMD_W       = 16;
    localparam int ACT_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int DELAY_BITS_DEF = 10;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_READ    = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [HALF_W-1:0] HALF_PERIOD_RST = HALF_W'(6);
    localparam logic [CMD_W-1:0]  KEY_READ_RST    = CMD_W'(1792);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // Frame construction and key filtering
    localparam logic [1:0]        FRAME_TOP     = 2'b01;  // 0x40 marker
    localparam logic              FRAME_RD_BIT  = 1'b1;   // bit 0 on a read
    localparam logic              FRAME_WR_BIT  = 1'b0;
    localparam logic [BYTE_W-1:0] KEY_VALID_MSK = 8'h40;
    localparam logic [BYTE_W-1:0] KEY_NONE      = 8'hFF;
    localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = BIT_IDX_W'(8);

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_WRITE,
        KIND_READ
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SSET,
        PH_SHOLD,
        PH_WLOW,
        PH_WHIGH,
        PH_ALOW,
        PH_AHIGH,
        PH_GAP,
        PH_RLOW,
        PH_RHIGH,
        PH_NLOW,
        PH_NHIGH,
        PH_PLOW,
        PH_PHIGH,
        PH_PREL
    } t_phase;

    // One classified tick as it sits in the queue
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic              sda;
    } t_item;

    // One result beat
    typedef struct packed {
        logic              scl_level;
        logic              sda_pull_low;
        logic              busy;
        logic              rejected;
        logic              key_ready;
        logic [BYTE_W-1:0] key_code;
    } t_result;

    // Key code is only meaningful with bit 6 set and not all ones
    function automatic logic [BYTE_W-1:0] filter_key(input logic [BYTE_W-1:0] code);
        logic [BYTE_W-1:0] res;
        res = code;
        if ((code & KEY_VALID_MSK) == '0) res = '0;
        if (code == KEY_NONE) res = '0;
        return res;
    endfunction

endpackage

// ===== src/twdkm_front.sv =====
// Front end: decodes the action and builds the address frame for each tick.
`timescale 1ns / 1ps

module twdkm_front (
    input  logic [twdkm_pkg::ACT_W-1:0]  i_action,
    input  logic [twdkm_pkg::CMD_W-1:0]  i_command_word,
    input  logic                         i_sda_level,
    input  logic [twdkm_pkg::CMD_W-1:0]  i_key_read_cmd,
    output twdkm_pkg::t_item             o_item
);
    import twdkm_pkg::*;

    // Address bits 12..8 land in frame bits 5..1, bit 6 of the frame is forced high
    always_comb begin
        o_item.sda         = i_sda_level;
        o_item.kind        = KIND_TICK;
        o_item.first_byte  = '0;
        o_item.second_byte = '0;
        unique case (i_action)
            ACT_WRITE: begin
                o_item.kind        = KIND_WRITE;
                o_item.first_byte  = {FRAME_TOP, i_command_word[12:8], FRAME_WR_BIT};
                o_item.second_byte = i_command_word[BYTE_W-1:0];
            end
            ACT_READ: begin
                o_item.kind       = KIND_READ;
                o_item.first_byte = {FRAME_TOP, i_key_read_cmd[12:8], FRAME_RD_BIT};
            end
            default: begin
                o_item.kind = KIND_TICK;
            end
        endcase
    end

endmodule

// ===== src/twdkm_queue.sv =====
// Short FIFO that decouples the front end from the bus sequencer.
`timescale 1ns / 1ps

module twdkm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  twdkm_pkg::t_item  i_push_item,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output twdkm_pkg::t_item  o_pop_item
);
    import twdkm_pkg::*;

    t_item              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;
    logic               push, pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_slot[r_rd_ptr];

    assign push = i_push_valid & o_push_ready;
    assign pop  = o_pop_valid & i_pop_ready;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== src/twdkm_back.sv =====
// Back end: bus phase sequencer, one tick per beat, with a registered result.
`timescale 1ns / 1ps

module twdkm_back #(
    parameter int DELAY_BITS = twdkm_pkg::DELAY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  twdkm_pkg::t_item              i_item,
    input  logic [twdkm_pkg::HALF_W-1:0]  i_half_period,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output twdkm_pkg::t_result            o_res
);
    import twdkm_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [DELAY_BITS-1:0]  r_tick, n_tick;
    logic [BIT_IDX_W-1:0]   r_bit, n_bit;
    logic                   r_byte, n_byte;
    logic [BYTE_W-1:0]      r_shift, n_shift;
    logic [BYTE_W-1:0]      r_second, n_second;
    logic                   r_is_read, n_is_read;
    logic                   r_line_pull, n_line_pull;
    logic                   r_res_valid;
    t_result                r_res, n_res;

    logic [HALF_W+DELAY_BITS-1:0] half_ext;
    logic [DELAY_BITS-1:0]        hp;
    logic [DELAY_BITS:0]          tick_inc;
    logic                         last;
    logic                         fire;

    assign o_item_ready = !r_res_valid || i_res_ready;
    assign fire         = i_item_valid && o_item_ready;
    assign o_res_valid  = r_res_valid;
    assign o_res        = r_res;

    // Phase length, masked to the counter width, zero behaves as one
    always_comb begin
        half_ext = {{DELAY_BITS{1'b0}}, i_half_period};
        hp       = half_ext[DELAY_BITS-1:0];
        if (hp == '0) hp = DELAY_BITS'(1);
    end

    // One tick of the sequencer
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_shift     = r_shift;
        n_second    = r_second;
        n_is_read   = r_is_read;
        n_line_pull = r_line_pull;
        n_res       = '0;
        n_res.scl_level = 1'b1;
        tick_inc    = '0;
        last        = 1'b0;

        // command start or rejection
        if (i_item.kind != KIND_TICK) begin
            if (r_phase != PH_IDLE) begin
                n_res.rejected = 1'b1;
            end else begin
                n_is_read = (i_item.kind == KIND_READ);
                n_shift   = i_item.first_byte;
                n_second  = i_item.second_byte;
                n_byte    = 1'b0;
                n_bit     = '0;
                n_tick    = '0;
                n_phase   = PH_SSET;
            end
        end

        if (n_phase == PH_IDLE) begin
            n_line_pull = 1'b0;
        end else begin
            n_res.busy = 1'b1;
            // line levels for this phase
            unique case (n_phase)
                PH_SSET:  begin n_res.scl_level = 1'b1; n_res.sda_pull_low = 1'b0; end
                PH_SHOLD: begin n_res.scl_level = 1'b1; n_res.sda_pull_low = 1'b1; end
                PH_WLOW:  begin n_res.scl_level = 1'b0; n_res.sda_pull_low = ~n_shift[7]; end
                PH_WHIGH: begin n_res.scl_level = 1'b1; n_res.sda_pull_low = ~n_shift[7]; end
                PH_ALOW:  begin n_res.scl_level = 1'b0; n_res.sda_pull_low = 1'b0; end
                PH_AHIGH: begin n_res.scl_level = 1'b1; n_res.sda_pull_low = 1'b0; end
                PH_GAP:   begin n_res.scl_level = 1'b0; n_res.sda_pull_low = n_line_pull; end
                PH_RLOW:  begin n_res.scl_level = 1'b0; n_res.sda_pull_low = 1'b0; end
                PH_RHIGH: begin n_res.scl_level = 1'b1; n_res.sda_pull_low = 1'b0; end
                PH_NLOW:  begin n_res.scl_level = 1'b0; n_res.sda_pull_low = 1'b0; end
                PH_NHIGH: begin n_res.scl_level = 1'b1; n_res.sda_pull_low = 1'b0; end
                PH_PLOW:  begin n_res.scl_level = 1'b0; n_res.sda_pull_low = 1'b1; end
                PH_PHIGH: begin n_res.scl_level = 1'b1; n_res.sda_pull_low = 1'b1; end
                default:  begin n_res.scl_level = 1'b1; n_res.sda_pull_low = 1'b0; end
            endcase
            n_line_pull = n_res.sda_pull_low;

            tick_inc = {1'b0, n_tick} + 1'b1;
            last     = (tick_inc >= {1'b0, hp});
            if (!last) begin
                n_tick = tick_inc[DELAY_BITS-1:0];
            end else begin
                n_tick = '0;
                // phase advance
                unique case (n_phase)
                    PH_SSET:  n_phase = PH_SHOLD;
                    PH_SHOLD: begin
                        n_bit   = '0;
                        n_phase = PH_WLOW;
                    end
                    PH_WLOW:  n_phase = PH_WHIGH;
                    PH_WHIGH: begin
                        n_shift = {n_shift[BYTE_W-2:0], 1'b0};
                        n_bit   = n_bit + 1'b1;
                        n_phase = (n_bit >= BITS_PER_BYTE) ? PH_ALOW : PH_WLOW;
                    end
                    PH_ALOW:  n_phase = PH_AHIGH;
                    PH_AHIGH: begin
                        // master mirrors the slave's ack on the data line
                        n_line_pull = !i_item.sda;
                        if (n_is_read) begin
                            n_phase = PH_GAP;
                        end else if (!n_byte) begin
                            n_byte  = 1'b1;
                            n_shift = n_second;
                            n_bit   = '0;
                            n_phase = PH_WLOW;
                        end else begin
                            n_phase = PH_PLOW;
                        end
                    end
                    PH_GAP: begin
                        n_shift = '0;
                        n_bit   = '0;
                        n_phase = PH_RLOW;
                    end
                    PH_RLOW:  n_phase = PH_RHIGH;
                    PH_RHIGH: begin
                        n_shift = {n_shift[BYTE_W-2:0], i_item.sda};
                        n_bit   = n_bit + 1'b1;
                        n_phase = (n_bit >= BITS_PER_BYTE) ? PH_NLOW : PH_RLOW;
                    end
                    PH_NLOW:  n_phase = PH_NHIGH;
                    PH_NHIGH: n_phase = PH_PLOW;
                    PH_PLOW:  n_phase = PH_PHIGH;
                    PH_PHIGH: n_phase = PH_PREL;
                    default: begin
                        if (n_is_read) begin
                            n_res.key_ready = 1'b1;
                            n_res.key_code  = filter_key(n_shift);
                        end
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_byte      <= 1'b0;
            r_shift     <= '0;
            r_second    <= '0;
            r_is_read   <= 1'b0;
            r_line_pull <= 1'b0;
        end else if (fire) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_byte      <= n_byte;
            r_shift     <= n_shift;
            r_second    <= n_second;
            r_is_read   <= n_is_read;
            r_line_pull <= n_line_pull;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (fire) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== src/two_wire_display_key_master.sv =====
// Top level: two-wire display/key bus master with config registers.
//
//  Channel  Direction  Handshake                  Payload
//  in       to block   i_in_valid / o_in_ready    i_action, i_command_word, i_sda_level
//  out      from block o_out_valid / i_out_ready  o_scl_level, o_sda_pull_low, o_busy_res,
//                                                 o_rejected, o_key_ready, o_key_code
//  cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One tick beat per cycle sustained while the output is not stalled; a taken beat passes
// through the queue register, then the sequencer's result register.
// Synchronous active-low reset clears queue and sequencer, presets config registers.
// An output stall holds the result register; the two-entry queue keeps taking ticks
// until full, then o_in_ready drops. Config writes are always taken.
`timescale 1ns / 1ps

module two_wire_display_key_master #(
    parameter int DELAY_BITS = twdkm_pkg::DELAY_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [twdkm_pkg::ACT_W-1:0]      i_action,
    input  logic [twdkm_pkg::CMD_W-1:0]      i_command_word,
    input  logic                             i_sda_level,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_scl_level,
    output logic                             o_sda_pull_low,
    output logic                             o_busy_res,
    output logic                             o_rejected,
    output logic                             o_key_ready,
    output logic [twdkm_pkg::BYTE_W-1:0]     o_key_code,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [twdkm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [twdkm_pkg::CMD_W-1:0]      i_cfg_data
);
    import twdkm_pkg::*;

    logic [HALF_W-1:0] r_half_period;
    logic [CMD_W-1:0]  r_key_read_cmd;
    t_item             front_item;
    t_item             q_item;
    logic              q_valid;
    logic              q_ready;
    t_result           res;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period  <= HALF_PERIOD_RST;
            r_key_read_cmd <= KEY_READ_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HALF_PERIOD) begin
                r_half_period <= i_cfg_data[HALF_W-1:0];
            end else if (i_cfg_index == REG_KEY_READ) begin
                r_key_read_cmd <= i_cfg_data;
            end
        end
    end

    twdkm_front u_front (
        .i_action       (i_action),
        .i_command_word (i_command_word),
        .i_sda_level    (i_sda_level),
        .i_key_read_cmd (r_key_read_cmd),
        .o_item         (front_item)
    );

    twdkm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .o_push_ready (o_in_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    twdkm_back #(
        .DELAY_BITS (DELAY_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (q_valid),
        .o_item_ready  (q_ready),
        .i_item        (q_item),
        .i_half_period (r_half_period),
        .o_res_valid   (o_out_valid),
        .i_res_ready   (i_out_ready),
        .o_res         (res)
    );

    assign o_scl_level    = res.scl_level;
    assign o_sda_pull_low = res.sda_pull_low;
    assign o_busy_res     = res.busy;
    assign o_rejected     = res.rejected;
    assign o_key_ready    = res.key_ready;
    assign o_key_code     = res.key_code;

endmodule
